>>> hdl/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the contact request parser: frame limits,
// fault and part codes, and the command record passed from the front to the
// back through the queue.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int NETWORK_MAX = 32;
  localparam int DEST_MAX    = 64;
  localparam int LABEL_MAX   = 32;

  localparam int FIELD_MAX_A = (NETWORK_MAX > DEST_MAX) ? NETWORK_MAX : DEST_MAX;
  localparam int FIELD_MAX   = (FIELD_MAX_A > LABEL_MAX) ? FIELD_MAX_A : LABEL_MAX;
  localparam int FIELD_W     = $clog2(FIELD_MAX + 1);

  localparam logic [7:0] MAX_ENTRIES_B = 8'(MAX_ENTRIES);
  localparam logic [7:0] NETWORK_MAX_B = 8'(NETWORK_MAX);
  localparam logic [7:0] DEST_MAX_B    = 8'(DEST_MAX);
  localparam logic [7:0] LABEL_MAX_B   = 8'(LABEL_MAX);

  // frame header magic, first byte first
  localparam logic [7:0] MAGIC [8] = '{8'h4B, 8'h4B, 8'h41, 8'h42,
                                       8'h52, 8'h45, 8'h51, 8'h31};
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [3:0] HDR_VERSION   = 4'd8;
  localparam logic [3:0] HDR_REV_LAST  = 4'd12;

  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  localparam logic [4:0] COUNT_SAT  = 5'd31;
  localparam logic [11:0] LEN_SAT   = 12'd4095;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_MAGIC    = 4'd1;
  localparam logic [3:0] ERR_VERSION  = 4'd2;
  localparam logic [3:0] ERR_ZERO_REV = 4'd3;
  localparam logic [3:0] ERR_COUNT    = 4'd4;
  localparam logic [3:0] ERR_NETLEN   = 4'd5;
  localparam logic [3:0] ERR_NETCHAR  = 4'd6;
  localparam logic [3:0] ERR_NOCOLON  = 4'd7;
  localparam logic [3:0] ERR_DTYPE    = 4'd8;
  localparam logic [3:0] ERR_DLEN     = 4'd9;
  localparam logic [3:0] ERR_LABLEN   = 4'd10;
  localparam logic [3:0] ERR_LABCHAR  = 4'd11;
  localparam logic [3:0] ERR_TRUNC    = 4'd12;
  localparam logic [3:0] ERR_TRAILING = 4'd13;

  localparam logic [1:0] PART_NET   = 2'd0;
  localparam logic [1:0] PART_DTYPE = 2'd1;
  localparam logic [1:0] PART_DEST  = 2'd2;
  localparam logic [1:0] PART_LABEL = 2'd3;

  localparam logic KIND_TAG     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int OUT_DATA_W = 72;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);

  typedef enum logic [9:0] {
    PH_HEADER = 10'b00_0000_0001,
    PH_NETLEN = 10'b00_0000_0010,
    PH_NET    = 10'b00_0000_0100,
    PH_DTYPE  = 10'b00_0000_1000,
    PH_DLEN   = 10'b00_0001_0000,
    PH_DEST   = 10'b00_0010_0000,
    PH_LLEN   = 10'b00_0100_0000,
    PH_LABEL  = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_FAULT  = 10'b10_0000_0000
  } crp_phase_t;

  // one record per input byte that causes any result
  typedef struct packed {
    logic        has_tag;
    logic        has_verdict;
    logic [3:0]  idx;
    logic [1:0]  part;
    logic [7:0]  data;
    logic        accepted;
    logic [3:0]  err;
    logic [31:0] rev;
    logic [4:0]  count;
    logic [11:0] len;
  } crp_cmd_t;

endpackage

>>> hdl/crp_front.sv
// ----------------------------------------------------------------------------
// crp_front
// Byte parser: walks the header and entry fields, checks each byte and
// pushes one command record per byte that produces a tagged byte or verdict.
// ----------------------------------------------------------------------------
module crp_front import crp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] in_byte,
  input  logic     in_end,
  input  logic     q_full,
  output logic     push,
  output crp_cmd_t cmd
);

  crp_phase_t         phase_r, phase_nxt;
  logic [3:0]         hdr_pos_r, hdr_pos_nxt;
  logic [FIELD_W-1:0] rem_r, rem_nxt, rem_dec;
  logic [4:0]         ecnt_r, ecnt_nxt, ecnt_inc;
  logic [31:0]        rev_r, rev_nxt, rev_shift;
  logic [4:0]         etot_r, etot_nxt;
  logic               colon_r, colon_nxt, colon_upd;
  logic [3:0]         fault_r, fault_nxt, verdict_err;
  logic [11:0]        bytes_r, bytes_nxt;
  logic               emit;
  logic [1:0]         part;
  logic               accept;

  function automatic logic net_char_ok(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == CH_COLON || b == CH_DASH;
  endfunction

  function automatic logic label_char_ok(input logic [7:0] b);
    return b >= CH_PRINT_LO && b <= CH_PRINT_HI && b != CH_PERCENT;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign rev_shift = {rev_r[23:0], in_byte};
  assign rem_dec   = rem_r - FIELD_W'(1);
  assign ecnt_inc  = ecnt_r + 5'd1;
  assign colon_upd = colon_r || (in_byte == CH_COLON);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    rem_nxt     = rem_r;
    ecnt_nxt    = ecnt_r;
    rev_nxt     = rev_r;
    etot_nxt    = etot_r;
    colon_nxt   = colon_r;
    fault_nxt   = fault_r;
    emit        = 1'b0;
    part        = PART_NET;
    bytes_nxt   = (bytes_r < LEN_SAT) ? bytes_r + 12'd1 : bytes_r;

    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_pos_r < HDR_VERSION) begin
          if (in_byte != MAGIC[hdr_pos_r[2:0]]) begin
            phase_nxt = PH_FAULT;
            fault_nxt = ERR_MAGIC;
          end else begin
            hdr_pos_nxt = hdr_pos_r + 4'd1;
          end
        end else if (hdr_pos_r == HDR_VERSION) begin
          if (in_byte != FRAME_VERSION) begin
            phase_nxt = PH_FAULT;
            fault_nxt = ERR_VERSION;
          end else begin
            hdr_pos_nxt = hdr_pos_r + 4'd1;
          end
        end else if (hdr_pos_r <= HDR_REV_LAST) begin
          rev_nxt = rev_shift;
          if (hdr_pos_r == HDR_REV_LAST && rev_shift == 32'd0) begin
            phase_nxt = PH_FAULT;
            fault_nxt = ERR_ZERO_REV;
          end else begin
            hdr_pos_nxt = hdr_pos_r + 4'd1;
          end
        end else begin
          etot_nxt = (in_byte > 8'(COUNT_SAT)) ? COUNT_SAT : in_byte[4:0];
          if (in_byte == 8'd0 || in_byte > MAX_ENTRIES_B) begin
            phase_nxt = PH_FAULT;
            fault_nxt = ERR_COUNT;
          end else begin
            ecnt_nxt  = 5'd0;
            phase_nxt = PH_NETLEN;
          end
        end
      end
      PH_NETLEN: begin
        if (in_byte == 8'd0 || in_byte > NETWORK_MAX_B) begin
          phase_nxt = PH_FAULT;
          fault_nxt = ERR_NETLEN;
        end else begin
          rem_nxt   = in_byte[FIELD_W-1:0];
          colon_nxt = 1'b0;
          phase_nxt = PH_NET;
        end
      end
      PH_NET: begin
        if (!net_char_ok(in_byte)) begin
          phase_nxt = PH_FAULT;
          fault_nxt = ERR_NETCHAR;
        end else begin
          colon_nxt = colon_upd;
          rem_nxt   = rem_dec;
          if (rem_dec == '0 && !colon_upd) begin
            // last network byte without any colon is itself the fault
            phase_nxt = PH_FAULT;
            fault_nxt = ERR_NOCOLON;
          end else begin
            if (rem_dec == '0) phase_nxt = PH_DTYPE;
            emit = 1'b1;
            part = PART_NET;
          end
        end
      end
      PH_DTYPE: begin
        if (in_byte == 8'd0) begin
          phase_nxt = PH_FAULT;
          fault_nxt = ERR_DTYPE;
        end else begin
          phase_nxt = PH_DLEN;
          emit      = 1'b1;
          part      = PART_DTYPE;
        end
      end
      PH_DLEN: begin
        if (in_byte == 8'd0 || in_byte > DEST_MAX_B) begin
          phase_nxt = PH_FAULT;
          fault_nxt = ERR_DLEN;
        end else begin
          rem_nxt   = in_byte[FIELD_W-1:0];
          phase_nxt = PH_DEST;
        end
      end
      PH_DEST: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_LLEN;
        emit = 1'b1;
        part = PART_DEST;
      end
      PH_LLEN: begin
        if (in_byte == 8'd0 || in_byte > LABEL_MAX_B) begin
          phase_nxt = PH_FAULT;
          fault_nxt = ERR_LABLEN;
        end else begin
          rem_nxt   = in_byte[FIELD_W-1:0];
          phase_nxt = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (!label_char_ok(in_byte)) begin
          phase_nxt = PH_FAULT;
          fault_nxt = ERR_LABCHAR;
        end else begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            ecnt_nxt  = ecnt_inc;
            phase_nxt = (ecnt_inc == etot_r) ? PH_DONE : PH_NETLEN;
          end
          emit = 1'b1;
          part = PART_LABEL;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_FAULT;
        fault_nxt = ERR_TRAILING;
      end
      PH_FAULT: begin
      end
      default: begin
        phase_nxt = PH_FAULT;
      end
    endcase
  end

  assign verdict_err = (fault_nxt == ERR_NONE && phase_nxt != PH_DONE) ? ERR_TRUNC
                                                                        : fault_nxt;

  assign push = accept && (emit || in_end);

  always_comb begin
    cmd.has_tag     = emit;
    cmd.has_verdict = in_end;
    cmd.idx         = ecnt_r[3:0];
    cmd.part        = part;
    cmd.data        = in_byte;
    cmd.accepted    = (verdict_err == ERR_NONE);
    cmd.err         = verdict_err;
    cmd.rev         = rev_nxt;
    cmd.count       = etot_nxt;
    cmd.len         = bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end)) begin
      phase_r   <= PH_HEADER;
      hdr_pos_r <= 4'd0;
      rem_r     <= '0;
      ecnt_r    <= 5'd0;
      rev_r     <= 32'd0;
      etot_r    <= 5'd0;
      colon_r   <= 1'b0;
      fault_r   <= ERR_NONE;
      bytes_r   <= 12'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      rem_r     <= rem_nxt;
      ecnt_r    <= ecnt_nxt;
      rev_r     <= rev_nxt;
      etot_r    <= etot_nxt;
      colon_r   <= colon_nxt;
      fault_r   <= fault_nxt;
      bytes_r   <= bytes_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a recorded fault always parks the parser until frame end
  a_fault_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != ERR_NONE) |-> (phase_r == PH_FAULT))
    else $error("fault recorded outside fault phase");
`endif

endmodule

>>> hdl/crp_queue.sv
// ----------------------------------------------------------------------------
// crp_queue
// Short register queue of command records between parser and output stage.
// ----------------------------------------------------------------------------
module crp_queue import crp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  crp_cmd_t push_cmd,
  output logic     full,
  output logic     q_valid,
  input  logic     pop,
  output crp_cmd_t pop_cmd
);

  crp_cmd_t         slot_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, rptr_r;
  logic [QCW-1:0]   count_r, count_nxt;

  assign full    = (count_r == QCW'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign pop_cmd = slot_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCW'(1);
    else if (pop && !push) count_nxt = count_r - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QAW'(1);
      if (pop) rptr_r <= rptr_r + QAW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_cmd;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> hdl/crp_back.sv
// ----------------------------------------------------------------------------
// crp_back
// Output stage: turns each command record into one or two result beats,
// tagged byte first and verdict second, behind an output register.
// ----------------------------------------------------------------------------
module crp_back import crp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  crp_cmd_t              q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_kind,
  output logic                  out_last
);

  logic                  vld_r, vld_nxt;
  logic                  pend_r, pend_nxt;
  crp_cmd_t              hold_r, hold_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  kind_r, kind_nxt;
  logic                  last_r, last_nxt;
  logic                  load;

  function automatic logic [OUT_DATA_W-1:0] pack_tag(input crp_cmd_t c);
    return {(OUT_DATA_W - 14)'(0), c.data, c.part, c.idx};
  endfunction

  function automatic logic [OUT_DATA_W-1:0] pack_verdict(input crp_cmd_t c);
    return {(OUT_DATA_W - 68)'(0), c.len, c.count, c.rev, c.err, c.accepted, 14'd0};
  endfunction

  assign load  = !vld_r || out_ready;
  assign q_pop = load && !pend_r && q_valid;

  always_comb begin
    vld_nxt  = vld_r;
    pend_nxt = pend_r;
    hold_nxt = hold_r;
    data_nxt = data_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    if (load) begin
      if (pend_r) begin
        vld_nxt  = 1'b1;
        pend_nxt = 1'b0;
        data_nxt = pack_verdict(hold_r);
        kind_nxt = KIND_VERDICT;
        last_nxt = 1'b1;
      end else if (q_valid) begin
        vld_nxt = 1'b1;
        if (q_cmd.has_tag) begin
          data_nxt = pack_tag(q_cmd);
          kind_nxt = KIND_TAG;
          last_nxt = !q_cmd.has_verdict;
          pend_nxt = q_cmd.has_verdict;
          hold_nxt = q_cmd;
        end else begin
          data_nxt = pack_verdict(q_cmd);
          kind_nxt = KIND_VERDICT;
          last_nxt = 1'b1;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

`ifndef NO_ASSERTIONS
  // a pending verdict always sits behind a tagged beat still on the bus
  a_pend_behind_tag: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (vld_r && kind_r == KIND_TAG && !last_r))
    else $error("pending verdict without its tagged beat");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_ready) |=> ($stable(data_r) && $stable(pend_r)))
    else $error("output beat changed under stall");
`endif

endmodule

>>> hdl/contact_request_parser_unit.sv
// ----------------------------------------------------------------------------
// contact_request_parser_unit
// Request frame parser and validator: one frame byte per beat in, tagged
// entry bytes and one verdict per frame out.
// ----------------------------------------------------------------------------
// Path: each result beat is written to the queue, then to the output
//   register before it is valid.
// Throughput: one byte per cycle; a byte with a tagged byte and a verdict
//   takes two output beats. The four-entry queue holds input only once full.
// Reset: synchronous, active low; parser state and queue are cleared, and
//   each frame end returns the parser to its reset state.
module contact_request_parser_unit import crp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  input  logic                  in_tlast,   // frame_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] entry_index, [5:4] part, [13:6] entry_byte, [14] accepted,
  // [18:15] error_code, [50:19] revision, [55:51] entry_count,
  // [67:56] frame_length, [71:68] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // kind
  output logic                  out_tlast   // last_result
);

  logic     q_full, q_push, q_valid, q_pop;
  crp_cmd_t push_cmd, pop_cmd;

  crp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  crp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd)
  );

  crp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

>>> dv/contact_request_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// contact_request_parser_unit_tb
// Self-checking bench for the request frame parser. It streams whole frames
// (valid ones, ones broken at every checked field, truncated ones, ones with
// trailing bytes, and raw noise) one byte per beat. It predicts every tagged
// entry byte and every frame verdict, and compares each result beat field by
// field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module contact_request_parser_unit_tb;
  import crp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_BYTES = 260;

  typedef struct {
    logic        kind;
    logic [3:0]  idx;
    logic [1:0]  part;
    logic [7:0]  data;
    logic        accepted;
    logic [3:0]  err;
    logic [31:0] rev;
    logic [4:0]  count;
    logic [11:0] len;
    logic        last;
  } parse_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // parser state as the bench sees it
  crp_phase_t  pstate;
  logic [3:0]  hpos;
  logic [7:0]  field_left;
  logic [4:0]  ent_no;
  logic [31:0] rev_acc;
  logic [4:0]  ent_total;
  logic        colon_seen;
  logic [3:0]  fault;
  logic [11:0] nbytes;

  parse_result_t out_beats_q[$];
  logic [7:0]    frame_q[$];

  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int fails = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int beats_checked = 0;
  int frames_ok = 0;
  int frames_bad = 0;
  int cycle_cnt = 0;

  contact_request_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parser
  function automatic bit net_ok(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == CH_COLON || b == CH_DASH;
  endfunction

  function automatic bit label_ok(logic [7:0] b);
    return b >= CH_PRINT_LO && b <= CH_PRINT_HI && b != CH_PERCENT;
  endfunction

  function automatic void reset_parser();
    pstate = PH_HEADER;
    hpos = '0;
    field_left = '0;
    ent_no = '0;
    rev_acc = '0;
    ent_total = '0;
    colon_seen = 1'b0;
    fault = ERR_NONE;
    nbytes = '0;
  endfunction

  // only the first fault of a frame is kept
  function automatic void note_fault(logic [3:0] code);
    if (fault == ERR_NONE) fault = code;
    pstate = PH_FAULT;
  endfunction

  function automatic void parser_step(logic [7:0] b, logic eof);
    parse_result_t r;
    logic          emit;
    logic [1:0]    part;
    logic [3:0]    idx;
    emit = 1'b0;
    part = PART_NET;
    idx = ent_no[3:0];
    if (nbytes != LEN_SAT) nbytes++;
    case (pstate)
      PH_HEADER: begin
        if (hpos < 4'd8) begin
          if (b != MAGIC[hpos[2:0]]) note_fault(ERR_MAGIC);
          else hpos++;
        end else if (hpos == HDR_VERSION) begin
          if (b != FRAME_VERSION) note_fault(ERR_VERSION);
          else hpos++;
        end else if (hpos <= HDR_REV_LAST) begin
          rev_acc = {rev_acc[23:0], b};
          if (hpos == HDR_REV_LAST && rev_acc == '0) note_fault(ERR_ZERO_REV);
          else hpos++;
        end else begin
          ent_total = (b > 8'd31) ? COUNT_SAT : b[4:0];
          if (b == 8'd0 || b > MAX_ENTRIES_B) note_fault(ERR_COUNT);
          else begin
            ent_no = '0;
            pstate = PH_NETLEN;
          end
        end
      end
      PH_NETLEN: begin
        if (b == 8'd0 || b > NETWORK_MAX_B) note_fault(ERR_NETLEN);
        else begin
          field_left = b;
          colon_seen = 1'b0;
          pstate = PH_NET;
        end
      end
      PH_NET: begin
        if (!net_ok(b)) note_fault(ERR_NETCHAR);
        else begin
          if (b == CH_COLON) colon_seen = 1'b1;
          field_left--;
          // last network byte of a colon-less network is the faulting byte
          if (field_left == 8'd0 && !colon_seen) note_fault(ERR_NOCOLON);
          else begin
            if (field_left == 8'd0) pstate = PH_DTYPE;
            emit = 1'b1;
            part = PART_NET;
          end
        end
      end
      PH_DTYPE: begin
        if (b == 8'd0) note_fault(ERR_DTYPE);
        else begin
          pstate = PH_DLEN;
          emit = 1'b1;
          part = PART_DTYPE;
        end
      end
      PH_DLEN: begin
        if (b == 8'd0 || b > DEST_MAX_B) note_fault(ERR_DLEN);
        else begin
          field_left = b;
          pstate = PH_DEST;
        end
      end
      PH_DEST: begin
        field_left--;
        if (field_left == 8'd0) pstate = PH_LLEN;
        emit = 1'b1;
        part = PART_DEST;
      end
      PH_LLEN: begin
        if (b == 8'd0 || b > LABEL_MAX_B) note_fault(ERR_LABLEN);
        else begin
          field_left = b;
          pstate = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (!label_ok(b)) note_fault(ERR_LABCHAR);
        else begin
          field_left--;
          if (field_left == 8'd0) begin
            ent_no = ent_no + 5'd1;
            pstate = (ent_no == ent_total) ? PH_DONE : PH_NETLEN;
          end
          emit = 1'b1;
          part = PART_LABEL;
        end
      end
      PH_DONE: note_fault(ERR_TRAILING);
      default: ;
    endcase

    if (emit) begin
      r = '{kind: KIND_TAG, idx: idx, part: part, data: b, accepted: 1'b0,
            err: ERR_NONE, rev: '0, count: '0, len: '0, last: !eof};
      out_beats_q.push_back(r);
    end
    if (eof) begin
      if (fault == ERR_NONE && pstate != PH_DONE) fault = ERR_TRUNC;
      r = '{kind: KIND_VERDICT, idx: '0, part: '0, data: '0,
            accepted: fault == ERR_NONE, err: fault, rev: rev_acc,
            count: ent_total, len: nbytes, last: 1'b1};
      out_beats_q.push_back(r);
      if (fault == ERR_NONE) frames_ok++;
      else frames_bad++;
      reset_parser();
    end
  endfunction

  // ------------------------------------------------------------ frame build
  function automatic logic [7:0] any_net_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? CH_COLON : CH_DASH;
  endfunction

  function automatic logic [7:0] plain_net_char();
    logic [7:0] v;
    do v = any_net_char(); while (v == CH_COLON);
    return v;
  endfunction

  function automatic logic [7:0] bad_net_char();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (net_ok(v));
    return v;
  endfunction

  function automatic logic [7:0] good_label_char();
    logic [7:0] v;
    do v = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)); while (v == CH_PERCENT);
    return v;
  endfunction

  function automatic logic [7:0] bad_label_char();
    logic [7:0] v;
    if ($urandom_range(0, 2) == 0) return CH_PERCENT;
    do v = 8'($urandom_range(0, 255)); while (label_ok(v));
    return v;
  endfunction

  // zero or anything above the field maximum
  function automatic logic [7:0] bad_len(int fmax);
    if ($urandom_range(0, 1) == 0) return 8'd0;
    return 8'($urandom_range(fmax + 1, 255));
  endfunction

  function automatic int pick_len(int fmax, int lmax, bit full);
    if (full) return fmax;
    return $urandom_range(1, (fmax < lmax) ? fmax : lmax);
  endfunction

  // appends one entry; returns 1 once a fault byte has been placed
  function automatic bit push_entry(logic [3:0] code, int nl, int dl, int ll);
    int cpos;
    if (code == ERR_NETLEN) begin
      frame_q.push_back(bad_len(NETWORK_MAX));
      return 1'b1;
    end
    frame_q.push_back(8'(nl));
    cpos = $urandom_range(0, nl - 1);
    for (int k = 0; k < nl; k++) begin
      if (code == ERR_NETCHAR && k == cpos) begin
        frame_q.push_back(bad_net_char());
        return 1'b1;
      end
      if (code == ERR_NOCOLON) frame_q.push_back(plain_net_char());
      else frame_q.push_back((k == cpos) ? CH_COLON : any_net_char());
    end
    if (code == ERR_NOCOLON) return 1'b1;
    if (code == ERR_DTYPE) begin
      frame_q.push_back(8'd0);
      return 1'b1;
    end
    frame_q.push_back(8'($urandom_range(1, 255)));
    if (code == ERR_DLEN) begin
      frame_q.push_back(bad_len(DEST_MAX));
      return 1'b1;
    end
    frame_q.push_back(8'(dl));
    for (int k = 0; k < dl; k++) frame_q.push_back(8'($urandom_range(0, 255)));
    if (code == ERR_LABLEN) begin
      frame_q.push_back(bad_len(LABEL_MAX));
      return 1'b1;
    end
    frame_q.push_back(8'(ll));
    cpos = $urandom_range(0, ll - 1);
    for (int k = 0; k < ll; k++) begin
      if (code == ERR_LABCHAR && k == cpos) begin
        frame_q.push_back(bad_label_char());
        return 1'b1;
      end
      frame_q.push_back(good_label_char());
    end
    return 1'b0;
  endfunction

  // well-formed frame with random content, broken as the fault code asks
  function automatic void build_frame(logic [3:0] code, int n_ent, int lmax, bit full);
    logic [31:0] rv;
    int          tgt;
    int          cut;
    bit          stop;
    frame_q.delete();
    case ($urandom_range(0, 3))
      0:       rv = 32'hFFFF_FFFF;
      1:       rv = $urandom_range(1, 255);
      default: rv = $urandom;
    endcase
    if (rv == '0) rv = 32'd1;
    if (code == ERR_ZERO_REV) rv = '0;
    for (int k = 0; k < 8; k++) frame_q.push_back(MAGIC[k]);
    if (code == ERR_MAGIC) frame_q[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    frame_q.push_back((code == ERR_VERSION) ?
                      FRAME_VERSION ^ 8'($urandom_range(1, 255)) : FRAME_VERSION);
    frame_q.push_back(rv[31:24]);
    frame_q.push_back(rv[23:16]);
    frame_q.push_back(rv[15:8]);
    frame_q.push_back(rv[7:0]);
    frame_q.push_back((code == ERR_COUNT) ? bad_len(MAX_ENTRIES) : 8'(n_ent));
    tgt = $urandom_range(0, n_ent - 1);
    stop = 1'b0;
    for (int e = 0; e < n_ent && !stop; e++)
      stop = push_entry((e == tgt) ? code : ERR_NONE, pick_len(NETWORK_MAX, lmax, full),
                        pick_len(DEST_MAX, lmax, full), pick_len(LABEL_MAX, lmax, full));
    // bytes after a fault are only counted
    if (stop) repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
    if (code == ERR_TRAILING)
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
    if (code == ERR_TRUNC) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endfunction

  function automatic void build_noise(int n);
    frame_q.delete();
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eof;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    parser_step(b, eof);
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (out_beats_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------- checking
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_beats_q.size() == 0) begin
        $error("result beat with nothing pending: tuser %0b tdata 0x%0h",
               out_tuser, out_tdata);
        fails++;
      end else begin
        want = out_beats_q.pop_front();
        beats_checked++;
        check_field("kind", want.kind, out_tuser);
        check_field("entry_index", want.idx, out_tdata[3:0]);
        check_field("part", want.part, out_tdata[5:4]);
        check_field("entry_byte", want.data, out_tdata[13:6]);
        check_field("accepted", want.accepted, out_tdata[14]);
        check_field("error_code", want.err, out_tdata[18:15]);
        check_field("revision", want.rev, out_tdata[50:19]);
        check_field("entry_count", want.count, out_tdata[55:51]);
        check_field("frame_length", want.len, out_tdata[67:56]);
        check_field("pad", '0, out_tdata[71:68]);
        check_field("last_result", want.last, out_tlast);
      end
    end
  end

  // result side: per beat a random stall before raising tready
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 11) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt, out_beats_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------ tests
  // smallest legal frame with extreme values, and a one-byte bad frame
  task automatic test_directed();
    build_noise(1);
    frame_q[0] = 8'h00;
    send_frame();
    frame_q.delete();
    for (int k = 0; k < 8; k++) frame_q.push_back(MAGIC[k]);
    frame_q.push_back(FRAME_VERSION);
    repeat (4) frame_q.push_back(8'hFF);
    frame_q.push_back(8'd1);
    frame_q.push_back(8'd1);
    frame_q.push_back(CH_COLON);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'd1);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'd1);
    frame_q.push_back(CH_PRINT_HI);
    send_frame();
  endtask

  task automatic test_each_fault();
    for (int c = ERR_MAGIC; c <= ERR_TRAILING; c++) begin
      build_frame(4'(c), $urandom_range(1, 3), 6, 1'b0);
      send_frame();
    end
    hold_until_drained();
  endtask

  // full count, full field lengths, and a frame with no idles on either side
  task automatic test_extremes();
    build_frame(ERR_NONE, 1, 0, 1'b1);
    send_frame();
    build_frame(ERR_NONE, MAX_ENTRIES, 3, 1'b0);
    send_frame();
    hold_until_drained();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    build_frame(ERR_NONE, 1, 4, 1'b0);
    send_frame();
    hold_until_drained();
  endtask

  task automatic test_random();
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        in_gaps_on = $urandom_range(0, 2) != 0;
        out_stalls_on = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 90)
        build_frame((r < 55) ? ERR_NONE : 4'($urandom_range(ERR_MAGIC, ERR_TRAILING)),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_ENTRIES)
                                                : $urandom_range(1, 3),
                    ($urandom_range(0, 9) == 0) ? 16 : 4, 1'b0);
      else
        build_noise($urandom_range(1, 20));
      send_frame();
      if ($urandom_range(0, 15) == 0) hold_until_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    reset_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_each_fault();
    test_extremes();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    test_random();

    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("%0d frames, %0d bytes streamed; %0d result beats compared",
             frames_sent, bytes_sent, beats_checked);
    $display("verdicts: %0d frames clean, %0d frames rejected", frames_ok, frames_bad);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
